@@ sv/crom_pkg.sv @@
// shared constants and types for the catmull-rom interpolator
// no dependencies; used by every module of the block
`default_nettype none

package crom_pkg;

  // pipeline layout: one register stage per entry
  localparam int NUM_STAGES = 7;
  localparam int ST_IN      = 0;  // input capture, t sampled with the item
  localparam int ST_SQ      = 1;  // t squared
  localparam int ST_CUBE    = 2;  // t cubed
  localparam int ST_WT      = 3;  // basis weights
  localparam int ST_MUL     = 4;  // weight times point products
  localparam int ST_SUM     = 5;  // sum of four products
  localparam int ST_OUT     = 6;  // rounded and saturated result

  localparam int NUM_POINTS = 4;
  localparam int NUM_COORDS = 3;

  // extra bits on the doubled weights over t: sign plus range up to 2.0
  localparam int WEIGHT_EXTRA = 3;

  // register index as decoded from paddr[2]
  localparam logic REG_T_FRACTION = 1'b0;

  // one advance strobe per stage
  typedef logic [NUM_STAGES-1:0] stage_vec_t;

endpackage

`default_nettype wire

@@ sv/catmull_rom_interpolator_xyz_core.sv @@
// Uniform Catmull-Rom spline evaluator for 3-D points. Each input item holds
// four control points (x, y, z each signed Q16.8 at the default width) and
// gives one result item: the spline at the t held in the t_fraction register
// (unsigned Q0.16, reset 0.5), rounded to nearest and saturated. The block is
// a seven-stage pipeline: input capture, t squared, t cubed, weights, products,
// sum, round. It takes one item per clock cycle while the output is not stalled;
// the rate is set by the fully pipelined multipliers, and an output stall holds
// the pipeline while empty stages still fill.
// The value of t is sampled with each item as it is accepted.
// Depends on crom_pkg, crom_weights and crom_lane.
`default_nettype none

module catmull_rom_interpolator_xyz_core #(
  parameter int COORD_WIDTH = 24,
  parameter int T_WIDTH     = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
  input  logic [((crom_pkg::NUM_POINTS*crom_pkg::NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_x, out_y, out_z
  output logic [((crom_pkg::NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] m_tdata
);

  localparam int WW    = T_WIDTH + crom_pkg::WEIGHT_EXTRA;
  localparam int OUT_W = ((crom_pkg::NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;

  logic [T_WIDTH-1:0]          t_fraction;
  logic                        cfg_wr;
  crom_pkg::stage_vec_t        adv;
  crom_pkg::stage_vec_t        vld;
  logic signed [WW-1:0]        weight [crom_pkg::NUM_POINTS];
  logic signed [COORD_WIDTH-1:0] pt_in [crom_pkg::NUM_COORDS][crom_pkg::NUM_POINTS];
  logic signed [COORD_WIDTH-1:0] res   [crom_pkg::NUM_COORDS];

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == crom_pkg::REG_T_FRACTION);

  always_ff @(posedge clk) begin
    if (rst) begin
      t_fraction <= T_WIDTH'(1) << (T_WIDTH - 1);
    end else if (cfg_wr) begin
      t_fraction <= pwdata[T_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == crom_pkg::REG_T_FRACTION) begin
      prdata = 32'(t_fraction);
    end
  end

  // stage advance: a stage loads when it is empty or its successor moves
  always_comb begin
    adv[crom_pkg::NUM_STAGES-1] = !vld[crom_pkg::NUM_STAGES-1] || m_tready;
    for (int k = crom_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < crom_pkg::NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = adv[0];
  assign m_tvalid = vld[crom_pkg::NUM_STAGES-1];

  // weight generator shared by all three lanes
  crom_weights #(
    .T_WIDTH (T_WIDTH)
  ) u_weights (
    .clk    (clk),
    .adv    (adv),
    .t_in   (t_fraction),
    .weight (weight)
  );

  // one lane per coordinate
  for (genvar c = 0; c < crom_pkg::NUM_COORDS; c++) begin : g_lane
    for (genvar j = 0; j < crom_pkg::NUM_POINTS; j++) begin : g_pt
      assign pt_in[c][j] =
        s_tdata[(j * crom_pkg::NUM_COORDS + c) * COORD_WIDTH +: COORD_WIDTH];
    end

    crom_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .T_WIDTH     (T_WIDTH)
    ) u_lane (
      .clk    (clk),
      .adv    (adv),
      .pt_in  (pt_in[c]),
      .weight (weight),
      .res    (res[c])
    );
  end

  // result packing, x in the lowest bits
  assign m_tdata = OUT_W'({res[2], res[1], res[0]});

endmodule

`default_nettype wire

@@ sv/crom_weights.sv @@
// basis weight generator: t^2, t^3 and the four doubled weights, pipelined
// depends on crom_pkg for stage layout
`default_nettype none

module crom_weights #(
  parameter int T_WIDTH = 16
) (
  input  logic                                                 clk,
  input  crom_pkg::stage_vec_t                                 adv,
  input  logic [T_WIDTH-1:0]                                   t_in,
  output logic signed [T_WIDTH+crom_pkg::WEIGHT_EXTRA-1:0]     weight [crom_pkg::NUM_POINTS]
);

  localparam int WW = T_WIDTH + crom_pkg::WEIGHT_EXTRA;
  localparam int PW = 2 * T_WIDTH;

  logic [T_WIDTH-1:0] u0;
  logic [T_WIDTH-1:0] u1;
  logic [T_WIDTH-1:0] t2_1;
  logic [T_WIDTH-1:0] u2;
  logic [T_WIDTH-1:0] t2_2;
  logic [T_WIDTH-1:0] t3_2;
  logic [PW-1:0]      sq;
  logic [PW-1:0]      cube;
  logic signed [WW-1:0] su;
  logic signed [WW-1:0] s2;
  logic signed [WW-1:0] s3;
  logic signed [WW-1:0] two_one;

  // square and cube with round half up
  assign sq   = PW'(u0) * PW'(u0) + (PW'(1) << (T_WIDTH - 1));
  assign cube = PW'(t2_1) * PW'(u1) + (PW'(1) << (T_WIDTH - 1));

  // zero-extended operands for the weight sums
  assign su      = WW'(u2);
  assign s2      = WW'(t2_2);
  assign s3      = WW'(t3_2);
  assign two_one = WW'(1) << (T_WIDTH + 1);

  // t sampled with the item
  always_ff @(posedge clk) begin
    if (adv[crom_pkg::ST_IN]) begin
      u0 <= t_in;
    end
  end

  // t^2 stage
  always_ff @(posedge clk) begin
    if (adv[crom_pkg::ST_SQ]) begin
      u1   <= u0;
      t2_1 <= sq[PW-1:T_WIDTH];
    end
  end

  // t^3 stage
  always_ff @(posedge clk) begin
    if (adv[crom_pkg::ST_CUBE]) begin
      u2   <= u1;
      t2_2 <= t2_1;
      t3_2 <= cube[PW-1:T_WIDTH];
    end
  end

  // doubled basis weights; the true values fit, intermediates wrap harmlessly
  always_ff @(posedge clk) begin
    if (adv[crom_pkg::ST_WT]) begin
      weight[0] <= -s3 + (s2 <<< 1) - su;
      weight[1] <= (s3 <<< 1) + s3 - (s2 <<< 2) - s2 + two_one;
      weight[2] <= -(s3 <<< 1) - s3 + (s2 <<< 2) + su;
      weight[3] <= s3 - s2;
    end
  end

endmodule

`default_nettype wire

@@ sv/crom_lane.sv @@
// one coordinate lane: point delay, products, sum, round and saturate
// depends on crom_pkg for stage layout
`default_nettype none

module crom_lane #(
  parameter int COORD_WIDTH = 24,
  parameter int T_WIDTH     = 16
) (
  input  logic                                              clk,
  input  crom_pkg::stage_vec_t                              adv,
  input  logic signed [COORD_WIDTH-1:0]                     pt_in  [crom_pkg::NUM_POINTS],
  input  logic signed [T_WIDTH+crom_pkg::WEIGHT_EXTRA-1:0]  weight [crom_pkg::NUM_POINTS],
  output logic signed [COORD_WIDTH-1:0]                     res
);

  localparam int WW = T_WIDTH + crom_pkg::WEIGHT_EXTRA;
  localparam int PW = WW + COORD_WIDTH;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] CMAX =
    {{(SW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN =
    {{(SW - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

  logic signed [COORD_WIDTH-1:0] pt [crom_pkg::ST_WT+1][crom_pkg::NUM_POINTS];
  logic signed [PW-1:0]          prod [crom_pkg::NUM_POINTS];
  logic signed [SW-1:0]          acc;
  logic signed [SW-1:0]          rnd;
  logic signed [SW-1:0]          shr;

  // points ride along while the weights are built
  always_ff @(posedge clk) begin
    if (adv[crom_pkg::ST_IN]) begin
      pt[crom_pkg::ST_IN] <= pt_in;
    end
    if (adv[crom_pkg::ST_SQ]) begin
      pt[crom_pkg::ST_SQ] <= pt[crom_pkg::ST_IN];
    end
    if (adv[crom_pkg::ST_CUBE]) begin
      pt[crom_pkg::ST_CUBE] <= pt[crom_pkg::ST_SQ];
    end
    if (adv[crom_pkg::ST_WT]) begin
      pt[crom_pkg::ST_WT] <= pt[crom_pkg::ST_CUBE];
    end
  end

  // four signed products
  always_ff @(posedge clk) begin
    if (adv[crom_pkg::ST_MUL]) begin
      for (int j = 0; j < crom_pkg::NUM_POINTS; j++) begin
        prod[j] <= PW'(weight[j]) * PW'(pt[crom_pkg::ST_WT][j]);
      end
    end
  end

  // weighted sum
  always_ff @(posedge clk) begin
    if (adv[crom_pkg::ST_SUM]) begin
      acc <= SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]) + SW'(prod[3]);
    end
  end

  // round to nearest, ties up, and drop the doubling and fraction bits
  assign rnd = acc + (SW'(1) << T_WIDTH);
  assign shr = rnd >>> (T_WIDTH + 1);

  // saturate to the coordinate range
  always_ff @(posedge clk) begin
    if (adv[crom_pkg::ST_OUT]) begin
      if (shr > CMAX) begin
        res <= CMAX[COORD_WIDTH-1:0];
      end else if (shr < CMIN) begin
        res <= CMIN[COORD_WIDTH-1:0];
      end else begin
        res <= shr[COORD_WIDTH-1:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ test/tb_catmull_rom_interpolator_xyz_core.sv @@
// testbench for catmull_rom_interpolator_xyz_core: spline results are checked against a
// built-in fixed-point predictor under random stalls on both streams and several t settings
// depends on crom_pkg and the core rtl only
`default_nettype none

module tb_catmull_rom_interpolator_xyz_core;

  localparam int COORD_W  = 24;
  localparam int T_W      = 16;
  localparam int NUM_CTRL = crom_pkg::NUM_POINTS * crom_pkg::NUM_COORDS;
  localparam int S_W      = ((NUM_CTRL * COORD_W + 7) / 8) * 8;
  localparam int M_W      = ((crom_pkg::NUM_COORDS * COORD_W + 7) / 8) * 8;
  localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN = -(1 << (COORD_W - 1));
  localparam int CYCLE_LIMIT = 400000;

  // register byte addresses, decoded by the block on paddr[2]
  localparam logic [2:0] ADDR_T_FRACTION = {crom_pkg::REG_T_FRACTION, 2'b00};
  localparam logic [2:0] ADDR_SPARE      = {~crom_pkg::REG_T_FRACTION, 2'b00};

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } xyz_t;

  // queue of predicted spline points, one per accepted item
  class spline_scoreboard;
    xyz_t expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // weighted sum of one coordinate, rounded half up and clamped
    function coord_t blend(longint w[4], coord_t p0, coord_t p1, coord_t p2, coord_t p3);
      longint acc;
      longint r;
      acc = w[0] * longint'(p0) + w[1] * longint'(p1) + w[2] * longint'(p2)
          + w[3] * longint'(p3);
      r = (acc + (longint'(1) <<< T_W)) >>> (T_W + 1);
      if (r > COORD_MAX) r = COORD_MAX;
      if (r < COORD_MIN) r = COORD_MIN;
      return coord_t'(r);
    endfunction

    // accepted item: build doubled basis weights from t and predict the point
    function void note_item(logic [T_W-1:0] t, coord_t pts[NUM_CTRL]);
      longint u;
      longint t2;
      longint t3;
      longint w[4];
      coord_t c[crom_pkg::NUM_COORDS];
      xyz_t e;
      u  = longint'(t);
      t2 = (u * u + (longint'(1) <<< (T_W - 1))) >>> T_W;
      t3 = (t2 * u + (longint'(1) <<< (T_W - 1))) >>> T_W;
      w[0] = -t3 + 2 * t2 - u;
      w[1] = 3 * t3 - 5 * t2 + 2 * (longint'(1) <<< T_W);
      w[2] = -3 * t3 + 4 * t2 + u;
      w[3] = t3 - t2;
      for (int k = 0; k < crom_pkg::NUM_COORDS; k++)
        c[k] = blend(w, pts[k], pts[crom_pkg::NUM_COORDS + k],
                     pts[2 * crom_pkg::NUM_COORDS + k],
                     pts[3 * crom_pkg::NUM_COORDS + k]);
      e.x = c[0];
      e.y = c[1];
      e.z = c[2];
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, coord_t exp_v, coord_t got_v);
      if (got_v !== exp_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    // accepted result item against the oldest prediction
    function void check_result(logic [M_W-1:0] data);
      xyz_t e;
      if (expected_q.size() == 0) begin
        $error("result item with no item outstanding: %h", data);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("out_x", e.x, coord_t'(data[0 +: COORD_W]));
      compare_field("out_y", e.y, coord_t'(data[COORD_W +: COORD_W]));
      compare_field("out_z", e.z, coord_t'(data[2 * COORD_W +: COORD_W]));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid;
  logic s_tready;
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
  logic [S_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // out_x, out_y, out_z
  logic [M_W-1:0] m_tdata;

  spline_scoreboard sb = new();
  logic [T_W-1:0] t_cur;
  bit tx_dense;
  int unsigned ready_run;
  int unsigned ready_pick;
  int unsigned cycle_count;

  catmull_rom_interpolator_xyz_core #(
    .COORD_WIDTH(COORD_W),
    .T_WIDTH    (T_W)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure: long ready runs, short stalls, a few long stalls
  initial ready_run = 0;
  always @(posedge clk) begin
    if (ready_run == 0) begin
      ready_pick = $urandom_range(0, 19);
      if (ready_pick < 10) begin
        m_tready <= 1'b1;
        ready_run <= $urandom_range(1, 25);
      end else if (ready_pick < 18) begin
        m_tready <= 1'b0;
        ready_run <= $urandom_range(1, 3);
      end else begin
        m_tready <= 1'b0;
        ready_run <= $urandom_range(10, 40);
      end
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_dense) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return coord_t'(COORD_MAX);
      1: return coord_t'(COORD_MIN);
      2: return coord_t'(int'($urandom_range(0, 4095)) - 2048);
      3: return coord_t'(COORD_MAX - int'($urandom_range(0, 255)));
      4: return coord_t'(COORD_MIN + int'($urandom_range(0, 255)));
      default: return coord_t'($urandom());
    endcase
  endfunction

  // random control points: independent, clustered around a base, or rail to rail
  function automatic void random_points(output coord_t pts[NUM_CTRL]);
    int unsigned style;
    coord_t base;
    style = $urandom_range(0, 9);
    base  = rand_coord();
    for (int i = 0; i < NUM_CTRL; i++) begin
      if (style < 5)
        pts[i] = rand_coord();
      else if (style < 8)
        pts[i] = coord_t'(int'(base) + int'($urandom_range(0, 511)) - 256);
      else
        pts[i] = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : coord_t'(COORD_MIN);
    end
  endfunction

  // directed control point patterns: zeros, rails, saturation both ways, bit toggles
  function automatic void directed_points(int idx, output coord_t pts[NUM_CTRL]);
    int pt;
    int co;
    for (int i = 0; i < NUM_CTRL; i++) begin
      pt = i / crom_pkg::NUM_COORDS;
      co = i % crom_pkg::NUM_COORDS;
      case (idx)
        0: pts[i] = '0;
        1: pts[i] = coord_t'(COORD_MAX);
        2: pts[i] = coord_t'(COORD_MIN);
        // inner points at the top rail, outer at the bottom: overshoot high
        3: pts[i] = (pt == 1 || pt == 2) ? coord_t'(COORD_MAX) : coord_t'(COORD_MIN);
        // mirror image: overshoot low
        4: pts[i] = (pt == 1 || pt == 2) ? coord_t'(COORD_MIN) : coord_t'(COORD_MAX);
        5: pts[i] = (pt == 1) ? coord_t'(COORD_MAX) : '0;
        6: pts[i] = (pt == 0) ? coord_t'(COORD_MAX) : coord_t'(COORD_MIN);
        7: pts[i] = (i % 2 == 0) ? coord_t'(24'h555555) : coord_t'(24'hAAAAAA);
        8: pts[i] = (i % 2 == 0) ? coord_t'(24'hAAAAAA) : coord_t'(24'h555555);
        9: pts[i] = (co == 0) ? coord_t'(COORD_MAX) : (co == 1) ? coord_t'(COORD_MIN) : '0;
        // one lsb steps land on rounding ties
        10: pts[i] = coord_t'(pt % 2);
        11: pts[i] = coord_t'(-(pt % 2));
        default: pts[i] = coord_t'(pt * 256 + co);
      endcase
    end
  endfunction

  // one input item through the stream handshake
  task automatic send_points(input coord_t pts[NUM_CTRL]);
    logic [S_W-1:0] word;
    int unsigned gap;
    gap  = pick_gap();
    word = '0;
    for (int i = 0; i < NUM_CTRL; i++) word[i * COORD_W +: COORD_W] = pts[i];
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(t_cur, pts);
  endtask

  // register write: setup phase, then access phase, then the bus is left idle
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_T_FRACTION) t_cur = data[T_W-1:0];
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    coord_t pts[NUM_CTRL];
    tx_dense = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      random_points(pts);
      send_points(pts);
    end
    drain();
  endtask

  task automatic phase(input logic [2:0] addr, input logic [31:0] data, input int n);
    write_reg(addr, data);
    run_random(n);
  endtask

  // main sequence
  initial begin
    coord_t pts[NUM_CTRL];
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    t_cur     = T_W'(1 << (T_W - 1));
    tx_dense  = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value of t, directed items first
    for (int d = 0; d < 13; d++) begin
      directed_points(d, pts);
      send_points(pts);
    end
    drain();
    run_random(60);

    // t at both ends, the smallest step, masked upper bits, spare address, random
    phase(ADDR_T_FRACTION, 32'h0000_0000, 70);
    phase(ADDR_T_FRACTION, 32'h0000_FFFF, 70);
    phase(ADDR_T_FRACTION, 32'h0000_0001, 70);
    phase(ADDR_T_FRACTION, 32'hDEAD_4000, 70);
    phase(ADDR_SPARE, 32'h0000_1111, 70);
    for (int p = 0; p < 4; p++) phase(ADDR_T_FRACTION, $urandom(), 70);

    // let any stray result show up
    repeat (3 * crom_pkg::NUM_STAGES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
